// ----- rtl/cbfp_pkg.sv -----
// ----------------------------------------------------------------------------
// cbfp_pkg
// Shared types and constants for the camera blob frame parser.
// ----------------------------------------------------------------------------
package cbfp_pkg;

    localparam logic [7:0] SYNC_LO   = 8'h55;
    localparam logic [7:0] SYNC_HI   = 8'hAA;
    localparam int         WIN_DEPTH = 16;
    localparam logic [4:0] BLOCK_LEN = 5'd14;
    localparam logic [4:0] FRAME_LEN = 5'd16;

    // Verdict on the window after the newest byte has been placed
    typedef enum logic [1:0] {
        VERDICT_INCOMPLETE,
        VERDICT_INVALID,
        VERDICT_FRAME,
        VERDICT_BLOCK
    } t_verdict;

    // One blob result as it travels from the window to the output buffer
    typedef struct packed {
        logic [15:0] blob_x;
        logic [15:0] blob_y;
        logic [15:0] blob_width;
        logic [15:0] blob_height;
        logic        frame_start;
        logic [3:0]  blob_index;
    } t_blob;

    // Little-endian word from two window bytes
    function automatic logic [15:0] word_le(input logic [7:0] lo, input logic [7:0] hi);
        return {hi, lo};
    endfunction

endpackage

// ----- rtl/cbfp_window.sv -----
// ----------------------------------------------------------------------------
// cbfp_window
// Byte window, sync and checksum check, per-frame blob counting.
// ----------------------------------------------------------------------------
module cbfp_window #(
    parameter int MAX_BLOBS_PER_FRAME = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_byte,
    output logic               o_blob_valid,
    output cbfp_pkg::t_blob    o_blob
);
    import cbfp_pkg::*;

    localparam logic [3:0] MAX_CNT = 4'(MAX_BLOBS_PER_FRAME);

    logic [7:0]  r_win [WIN_DEPTH];
    logic [4:0]  r_fill;
    logic [3:0]  r_count;

    logic [7:0]  w [WIN_DEPTH];
    logic [3:0]  wr_idx;
    logic [4:0]  new_fill;
    logic [15:0] sum_blk;
    logic [15:0] sum_frm;
    t_verdict    verdict;

    // A full window (never reached in practice) restarts at entry zero
    assign wr_idx   = r_fill[3:0];
    assign new_fill = {1'b0, r_fill[3:0]} + 5'd1;

    always_comb begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            w[i] = (4'(i) == wr_idx) ? i_byte : r_win[i];
        end
    end

    assign sum_blk = word_le(w[4], w[5]) + word_le(w[6], w[7]) + word_le(w[8], w[9])
                   + word_le(w[10], w[11]) + word_le(w[12], w[13]);
    assign sum_frm = word_le(w[6], w[7]) + word_le(w[8], w[9]) + word_le(w[10], w[11])
                   + word_le(w[12], w[13]) + word_le(w[14], w[15]);

    always_comb begin
        if (w[0] != SYNC_LO) begin
            verdict = VERDICT_INVALID;
        end else if (new_fill >= 5'd2 && w[1] != SYNC_HI) begin
            verdict = VERDICT_INVALID;
        end else if (new_fill < BLOCK_LEN) begin
            verdict = VERDICT_INCOMPLETE;
        end else if (w[2] == SYNC_LO && w[3] == SYNC_HI) begin
            if (new_fill < FRAME_LEN) begin
                verdict = VERDICT_INCOMPLETE;
            end else begin
                verdict = (sum_frm == word_le(w[4], w[5])) ? VERDICT_FRAME : VERDICT_INVALID;
            end
        end else begin
            verdict = (sum_blk == word_le(w[2], w[3])) ? VERDICT_BLOCK : VERDICT_INVALID;
        end
    end

    // Result fields
    always_comb begin
        o_blob_valid = 1'b0;
        o_blob       = '0;
        case (verdict)
            VERDICT_FRAME: begin
                o_blob_valid       = i_accept;
                o_blob.blob_x      = word_le(w[8], w[9]);
                o_blob.blob_y      = word_le(w[10], w[11]);
                o_blob.blob_width  = word_le(w[12], w[13]);
                o_blob.blob_height = word_le(w[14], w[15]);
                o_blob.frame_start = 1'b1;
                o_blob.blob_index  = 4'd0;
            end
            VERDICT_BLOCK: begin
                o_blob_valid       = i_accept && (r_count < MAX_CNT);
                o_blob.blob_x      = word_le(w[6], w[7]);
                o_blob.blob_y      = word_le(w[8], w[9]);
                o_blob.blob_width  = word_le(w[10], w[11]);
                o_blob.blob_height = word_le(w[12], w[13]);
                o_blob.frame_start = 1'b0;
                o_blob.blob_index  = r_count;
            end
            default: begin
                o_blob_valid = 1'b0;
            end
        endcase
    end

    // Window bytes: shift down on a bad head, otherwise take the new byte
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int i = 0; i < WIN_DEPTH; i++) begin
                if (verdict == VERDICT_INVALID) begin
                    r_win[i] <= (i == WIN_DEPTH - 1) ? 8'h00 : w[(i + 1) % WIN_DEPTH];
                end else begin
                    r_win[i] <= w[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            case (verdict)
                VERDICT_INCOMPLETE: r_fill <= new_fill;
                VERDICT_INVALID:    r_fill <= new_fill - 5'd1;
                VERDICT_FRAME: begin
                    r_fill  <= '0;
                    r_count <= 4'd1;
                end
                VERDICT_BLOCK: begin
                    r_fill <= '0;
                    if (r_count < MAX_CNT) begin
                        r_count <= r_count + 4'd1;
                    end
                end
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

// ----- rtl/cbfp_out_buf.sv -----
// ----------------------------------------------------------------------------
// cbfp_out_buf
// Two-entry result buffer between the parser and the output stream.
// ----------------------------------------------------------------------------
module cbfp_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  cbfp_pkg::t_blob    i_blob,
    input  logic               i_pop,
    output logic               o_valid,
    output logic               o_has_room,
    output cbfp_pkg::t_blob    o_blob
);
    import cbfp_pkg::*;

    t_blob       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        pop_ok;

    assign pop_ok     = i_pop && (r_count != 2'd0);
    assign o_valid    = (r_count != 2'd0);
    assign o_has_room = (r_count != 2'd2);
    assign o_blob     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_blob;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop_ok) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop_ok};
        end
    end

endmodule

// ----- rtl/camera_blob_frame_parser_unit.sv -----
// ----------------------------------------------------------------------------
// camera_blob_frame_parser_unit
// Sync-word framed blob parser for a serial camera byte stream.
// ----------------------------------------------------------------------------
// Takes one camera byte per clock cycle while s_axis_tready is high. Each
// accepted transaction is judged in the same cycle against a 16-byte window
// (sync pair 0x55 0xAA, 14-byte plain block or 16-byte frame start with a
// second sync pair, 16-bit sum of the five data words as checksum) in
// combinational logic with a five-word adder. A valid message yields one blob
// on the master side at the earliest in the cycle after its last byte is
// accepted, via a two-entry output buffer; s_axis_tready drops only while that
// buffer holds two results not yet taken. A bad sync or checksum drops the
// oldest byte; plain blocks beyond MAX_BLOBS_PER_FRAME blobs per frame drop.
// ----------------------------------------------------------------------------
module camera_blob_frame_parser_unit #(
    parameter int MAX_BLOBS_PER_FRAME = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] blob_x, [31:16] blob_y, [47:32] blob_width,
    // [63:48] blob_height, [67:64] blob_index, [71:68] zero
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tuser    // [0] frame_start
);
    import cbfp_pkg::*;

    logic  accept;
    logic  blob_valid;
    t_blob blob;
    t_blob out_blob;
    logic  has_room;

    // Hold input while the output buffer is full
    assign s_axis_tready = has_room;
    assign accept        = s_axis_tvalid && s_axis_tready;

    cbfp_window #(
        .MAX_BLOBS_PER_FRAME(MAX_BLOBS_PER_FRAME)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_byte       (s_axis_tdata),
        .o_blob_valid (blob_valid),
        .o_blob       (blob)
    );

    cbfp_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (blob_valid),
        .i_blob     (blob),
        .i_pop      (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_has_room (has_room),
        .o_blob     (out_blob)
    );

    // Pack the blob fields onto the stream, lowest field first
    assign m_axis_tdata = {4'h0, out_blob.blob_index, out_blob.blob_height,
                           out_blob.blob_width, out_blob.blob_y, out_blob.blob_x};
    assign m_axis_tuser = out_blob.frame_start;

    // A frame-start blob always opens the frame at index zero
    a_frame_start_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[67:64] == 4'd0))
        else $error("frame-start blob with non-zero index");

    // No blob index reaches the per-frame limit
    a_index_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[67:64] < 4'(MAX_BLOBS_PER_FRAME)))
        else $error("blob index beyond per-frame limit");

    // Nothing is presented straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("result presented after reset");

endmodule
